>>> rtl/core/io_timer_interrupt_registers_core_assert.svh
// Assertion macros for the I/O timer and interrupt register core.
// Depends on nothing; included by the top level only.
`ifndef IO_TIMER_INTERRUPT_REGISTERS_CORE_ASSERT_SVH
`define IO_TIMER_INTERRUPT_REGISTERS_CORE_ASSERT_SVH

// same-cycle implication
`define IOTIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iotir assertion failed");

// next-cycle implication
`define IOTIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iotir assertion failed");

`endif

>>> rtl/core/iotir_pkg.sv
// Shared types and constants for the I/O timer and interrupt register core.
// No dependencies.
`timescale 1ns / 1ps

package iotir_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    FN_READ   = 3'd0,
    FN_WRITE  = 3'd1,
    FN_TICK   = 3'd2,
    FN_CHECK  = 3'd3,
    FN_RETURN = 3'd4
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  localparam logic [4:0] REG_EN0     = 5'd0;
  localparam logic [4:0] REG_EN1     = 5'd1;
  localparam logic [4:0] REG_EN2     = 5'd2;
  localparam logic [4:0] REG_ST0     = 5'd3;
  localparam logic [4:0] REG_ST1     = 5'd4;
  localparam logic [4:0] REG_ST2     = 5'd5;
  localparam logic [4:0] REG_HANDLER = 5'd6;
  localparam logic [4:0] REG_RETURN  = 5'd7;
  localparam logic [4:0] REG_CLKS    = 5'd8;
  localparam logic [4:0] REG_TEN     = 5'd11;
  localparam logic [4:0] REG_TCUR    = 5'd12;
  localparam logic [4:0] REG_TMAX    = 5'd13;
  localparam logic [4:0] REG_DCMD    = 5'd14;
  localparam logic [4:0] REG_DSTAT   = 5'd17;
  localparam logic [4:0] REG_MCMD    = 5'd22;

  localparam logic [15:0] DISK_LAT_RESET  = 16'd1024;
  localparam word_t       DISK_DONE_RESET = 32'hFFFF_FFFF;

endpackage

>>> rtl/core/iotir_ctrl.sv
// Request controller: two-state FSM that sequences capture and execute.
// Depends on iotir_pkg.
`timescale 1ns / 1ps

module iotir_ctrl
  import iotir_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd,
  output logic out_valid
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = start ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = start ? ST_EXEC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // a new request enters every cycle; execution of the held one overlaps
  always_comb begin
    busy        = 1'b0;
    cmd.capture = start;
    case (state_r)
      ST_EXEC: cmd.exec = 1'b1;
      default: cmd.exec = 1'b0;
    endcase
    out_valid_nxt = cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/iotir_dp.sv
// Datapath: request registers, I/O register bank, timer, disk timer,
// interrupt logic and result registers. Depends on iotir_pkg.
`timescale 1ns / 1ps

module iotir_dp
  import iotir_pkg::*;
#(
  parameter int IO_REG_COUNT = 23,
  parameter int PC_WIDTH     = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic [2:0]          in_func,
  input  logic [4:0]          in_io_address,
  input  logic [31:0]         in_write_data,
  input  logic [PC_WIDTH-1:0] in_pc_value,
  input  logic                in_irq2_line,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output logic [31:0]         out_read_data,
  output logic                out_redirect,
  output logic [PC_WIDTH-1:0] out_target_pc,
  output logic                out_irq_pending
);

  logic [2:0]          func_r;
  logic [4:0]          addr_r;
  word_t               wdata_r;
  logic [PC_WIDTH-1:0] pc_r;
  logic                line2_r;

  word_t       bank_r   [IO_REG_COUNT];
  word_t       bank_nxt [IO_REG_COUNT];
  word_t       done_r, done_nxt;
  logic        in_handler_r, in_handler_nxt;
  logic [15:0] lat_r;

  word_t               rdata_r, rdata_nxt;
  logic                redirect_r, redirect_nxt;
  logic [PC_WIDTH-1:0] target_r, target_nxt;
  logic                pending_r, pending_nxt;

  logic addr_ok;
  logic pending_now;

  assign addr_ok = {1'b0, addr_r} < 6'(IO_REG_COUNT);

  assign pending_now = (bank_r[REG_EN0] != '0 && bank_r[REG_ST0] != '0) ||
                       (bank_r[REG_EN1] != '0 && bank_r[REG_ST1] != '0) ||
                       (bank_r[REG_EN2] != '0 && bank_r[REG_ST2] != '0);

  always_comb begin
    bank_nxt       = bank_r;
    done_nxt       = done_r;
    in_handler_nxt = in_handler_r;
    rdata_nxt      = '0;
    redirect_nxt   = 1'b0;
    target_nxt     = '0;
    case (func_t'(func_r))
      FN_READ: begin
        if (addr_ok) rdata_nxt = bank_r[addr_r];
      end
      FN_WRITE: begin
        if (addr_ok) begin
          if (addr_r == REG_DCMD && wdata_r != '0) begin
            bank_nxt[REG_DSTAT] = 32'd1;
            done_nxt            = bank_r[REG_CLKS] + {16'd0, lat_r};
          end
          bank_nxt[addr_r] = wdata_r;
        end
      end
      FN_TICK: begin
        bank_nxt[REG_MCMD] = '0;
        if (bank_r[REG_TEN] != '0) begin
          if (bank_r[REG_TCUR] == bank_r[REG_TMAX]) begin
            bank_nxt[REG_TCUR] = '0;
            bank_nxt[REG_ST0]  = 32'd1;
          end else begin
            bank_nxt[REG_TCUR] = bank_r[REG_TCUR] + 32'd1;
          end
        end
        if (bank_r[REG_CLKS] == done_r) begin
          bank_nxt[REG_ST1]   = 32'd1;
          bank_nxt[REG_DCMD]  = '0;
          bank_nxt[REG_DSTAT] = '0;
        end
        if (line2_r) bank_nxt[REG_ST2] = 32'd1;
        bank_nxt[REG_CLKS] = bank_r[REG_CLKS] + 32'd1;
      end
      FN_CHECK: begin
        if (pending_now && !in_handler_r) begin
          bank_nxt[REG_RETURN] = 32'(pc_r);
          target_nxt           = bank_r[REG_HANDLER][PC_WIDTH-1:0];
          redirect_nxt         = 1'b1;
          in_handler_nxt       = 1'b1;
        end
      end
      FN_RETURN: begin
        in_handler_nxt = 1'b0;
        target_nxt     = bank_r[REG_RETURN][PC_WIDTH-1:0];
        redirect_nxt   = 1'b1;
      end
      default: begin
      end
    endcase
    pending_nxt = (bank_nxt[REG_EN0] != '0 && bank_nxt[REG_ST0] != '0) ||
                  (bank_nxt[REG_EN1] != '0 && bank_nxt[REG_ST1] != '0) ||
                  (bank_nxt[REG_EN2] != '0 && bank_nxt[REG_ST2] != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      addr_r  <= in_io_address;
      wdata_r <= in_write_data;
      pc_r    <= in_pc_value;
      line2_r <= in_irq2_line;
    end
    if (cmd.exec) begin
      rdata_r    <= rdata_nxt;
      redirect_r <= redirect_nxt;
      target_r   <= target_nxt;
      pending_r  <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IO_REG_COUNT; i++) bank_r[i] <= '0;
      done_r       <= DISK_DONE_RESET;
      in_handler_r <= 1'b0;
      lat_r        <= DISK_LAT_RESET;
    end else begin
      if (cmd.exec) begin
        bank_r       <= bank_nxt;
        done_r       <= done_nxt;
        in_handler_r <= in_handler_nxt;
      end
      if (cfg_we) lat_r <= cfg_data;
    end
  end

  assign out_read_data   = rdata_r;
  assign out_redirect    = redirect_r;
  assign out_target_pc   = target_r;
  assign out_irq_pending = pending_r;

endmodule

>>> rtl/core/io_timer_interrupt_registers_core.sv
// Top level of the I/O timer and interrupt register core.
// Depends on iotir_pkg, iotir_ctrl, iotir_dp and the assertion macro header.
//
//   channel  | handshake           | payload
//   request  | start / busy        | in_func, in_io_address, in_write_data,
//            |                     | in_pc_value, in_irq2_line
//   result   | out_valid (strobe)  | out_read_data, out_redirect,
//            |                     | out_target_pc, out_irq_pending
//   config   | cfg_valid/cfg_ready | cfg_data (disk latency)
//
// One request per cycle; busy stays low. A request is registered at
// acceptance, executed in the next cycle and its result strobed the cycle
// after that.
// Synchronous active-low reset clears the bank and the FSM and sets the disk timer to its reset values.
// The result is shown for one cycle only; the receiver cannot stall it.
`timescale 1ns / 1ps

module io_timer_interrupt_registers_core
  import iotir_pkg::*;
#(
  parameter int IO_REG_COUNT = 23,
  parameter int PC_WIDTH     = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_func,
  input  logic [4:0]          in_io_address,
  input  logic [31:0]         in_write_data,
  input  logic [PC_WIDTH-1:0] in_pc_value,
  input  logic                in_irq2_line,
  output logic                out_valid,
  output logic [31:0]         out_read_data,
  output logic                out_redirect,
  output logic [PC_WIDTH-1:0] out_target_pc,
  output logic                out_irq_pending,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  iotir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  iotir_dp #(
    .IO_REG_COUNT (IO_REG_COUNT),
    .PC_WIDTH     (PC_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_func),
    .in_io_address   (in_io_address),
    .in_write_data   (in_write_data),
    .in_pc_value     (in_pc_value),
    .in_irq2_line    (in_irq2_line),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_read_data   (out_read_data),
    .out_redirect    (out_redirect),
    .out_target_pc   (out_target_pc),
    .out_irq_pending (out_irq_pending)
  );

`include "io_timer_interrupt_registers_core_assert.svh"

  `IOTIR_ASSERT_IMPLY(a_req_gives_result, clk, rst_n, start && !busy, ##2 out_valid)
  `IOTIR_ASSERT_IMPLY(a_result_has_req, clk, rst_n, out_valid, $past(start && !busy, 2))
  `IOTIR_ASSERT_NEXT(a_exec_follows_capture, clk, rst_n, cmd.capture, cmd.exec)

endmodule

>>> verif/io_timer_interrupt_registers_checker.sv
// Result checker for io_timer_interrupt_registers_core: keeps its own copy of the register
// bank, disk timer and handler flag, predicts each request's result and compares it.
// Depends on iotir_pkg; instantiated beside the core by the testbench top.
`timescale 1ns / 1ps

module io_timer_interrupt_registers_checker
  import iotir_pkg::*;
#(
  parameter int IO_REG_COUNT = 23,
  parameter int PC_WIDTH     = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [2:0]          in_func,
  input  logic [4:0]          in_io_address,
  input  logic [31:0]         in_write_data,
  input  logic [PC_WIDTH-1:0] in_pc_value,
  input  logic                in_irq2_line,
  input  logic                out_valid,
  input  logic [31:0]         out_read_data,
  input  logic                out_redirect,
  input  logic [PC_WIDTH-1:0] out_target_pc,
  input  logic                out_irq_pending,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  errors,
  output int                  outstanding
);

  typedef struct packed {
    word_t               read_data;
    logic                redirect;
    logic [PC_WIDTH-1:0] target_pc;
    logic                irq_pending;
  } io_result_t;

  word_t       bank [IO_REG_COUNT];
  word_t       disk_done;
  logic        handler_active;
  logic [15:0] disk_lat;
  io_result_t  pending_results [$];

  function automatic logic irq_raised();
    return (bank[REG_EN0] != 0 && bank[REG_ST0] != 0) ||
           (bank[REG_EN1] != 0 && bank[REG_ST1] != 0) ||
           (bank[REG_EN2] != 0 && bank[REG_ST2] != 0);
  endfunction

  function automatic io_result_t execute_request(logic [2:0] fn, logic [4:0] addr,
                                                 word_t wdata, logic [PC_WIDTH-1:0] pc,
                                                 logic line2);
    io_result_t r;
    r = '0;
    case (fn)
      FN_READ: begin
        if (addr < IO_REG_COUNT) r.read_data = bank[addr];
      end
      FN_WRITE: begin
        if (addr < IO_REG_COUNT) begin
          if (addr == REG_DCMD && wdata != 0) begin
            bank[REG_DSTAT] = 32'd1;
            disk_done = bank[REG_CLKS] + {16'd0, disk_lat};
          end
          bank[addr] = wdata;
        end
      end
      FN_TICK: begin
        bank[REG_MCMD] = '0;
        if (bank[REG_TEN] != 0) begin
          if (bank[REG_TCUR] == bank[REG_TMAX]) begin
            bank[REG_TCUR] = '0;
            bank[REG_ST0] = 32'd1;
          end else begin
            bank[REG_TCUR] = bank[REG_TCUR] + 32'd1;
          end
        end
        if (bank[REG_CLKS] == disk_done) begin
          bank[REG_ST1] = 32'd1;
          bank[REG_DCMD] = '0;
          bank[REG_DSTAT] = '0;
        end
        if (line2) bank[REG_ST2] = 32'd1;
        bank[REG_CLKS] = bank[REG_CLKS] + 32'd1;
      end
      FN_CHECK: begin
        if (irq_raised() && !handler_active) begin
          bank[REG_RETURN] = 32'(pc);
          r.target_pc = bank[REG_HANDLER][PC_WIDTH-1:0];
          r.redirect = 1'b1;
          handler_active = 1'b1;
        end
      end
      FN_RETURN: begin
        handler_active = 1'b0;
        r.target_pc = bank[REG_RETURN][PC_WIDTH-1:0];
        r.redirect = 1'b1;
      end
      default: ;
    endcase
    r.irq_pending = irq_raised();
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    io_result_t want;
    io_result_t got;
    if (!rst_n) begin
      foreach (bank[i]) bank[i] = '0;
      disk_done = DISK_DONE_RESET;
      handler_active = 1'b0;
      disk_lat = DISK_LAT_RESET;
      pending_results.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        got = '{out_read_data, out_redirect, out_target_pc, out_irq_pending};
        if (pending_results.size() == 0) begin
          $error("result strobed with no request outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            errors++;
          end
          if (got.redirect !== want.redirect) begin
            $error("redirect: expected %b, got %b", want.redirect, got.redirect);
            errors++;
          end
          if (got.target_pc !== want.target_pc) begin
            $error("target_pc: expected %h, got %h", want.target_pc, got.target_pc);
            errors++;
          end
          if (got.irq_pending !== want.irq_pending) begin
            $error("irq_pending: expected %b, got %b", want.irq_pending, got.irq_pending);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) disk_lat = cfg_data;
      if (start && !busy) begin
        pending_results.push_back(execute_request(in_func, in_io_address, in_write_data,
                                                  in_pc_value, in_irq2_line));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

>>> verif/testbench.sv
// Top of the io_timer_interrupt_registers_core testbench: clock, reset, directed and random
// requests, disk latency writes between phases, watchdog and verdict.
// Depends on iotir_pkg, the core and io_timer_interrupt_registers_checker.
`timescale 1ns / 1ps

module testbench;
  import iotir_pkg::*;

  localparam int         IO_REG_COUNT   = 23;
  localparam int         PC_WIDTH       = 12;
  localparam int         PHASE_REQUESTS = 300;
  localparam int         STALL_LIMIT    = 1000;
  localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FN_SPARE_LAST  = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [2:0]          in_func;
  logic [4:0]          in_io_address;
  logic [31:0]         in_write_data;
  logic [PC_WIDTH-1:0] in_pc_value;
  logic                in_irq2_line;
  logic                out_valid;
  logic [31:0]         out_read_data;
  logic                out_redirect;
  logic [PC_WIDTH-1:0] out_target_pc;
  logic                out_irq_pending;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [15:0]         cfg_data;
  int                  errors;
  int                  outstanding;

  int                  idle_pct;
  int                  sent;
  int                  quiet_cycles;
  logic [15:0]         cur_lat;

  always #5 clk = ~clk;

  io_timer_interrupt_registers_core #(
    .IO_REG_COUNT(IO_REG_COUNT),
    .PC_WIDTH    (PC_WIDTH)
  ) dut (.*);

  io_timer_interrupt_registers_checker #(
    .IO_REG_COUNT(IO_REG_COUNT),
    .PC_WIDTH    (PC_WIDTH)
  ) checker_i (.*);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic word_t any_word();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return word_t'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [4:0] rnd_addr();
    return 5'($urandom());
  endfunction

  function automatic logic [PC_WIDTH-1:0] rnd_pc();
    return PC_WIDTH'($urandom());
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic send(input logic [2:0] fn, input logic [4:0] addr, input word_t data,
                      input logic [PC_WIDTH-1:0] pc, input logic line);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= fn;
    in_io_address <= addr;
    in_write_data <= data;
    in_pc_value   <= pc;
    in_irq2_line  <= line;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // only while the core is drained
  task automatic set_latency(input logic [15:0] lat);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lat;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_lat = lat;
  endtask

  initial begin : stimulus
    int    phase;
    int    k;
    word_t base;
    logic [2:0] fn;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = FN_READ;
    in_io_address = '0;
    in_write_data = '0;
    in_pc_value   = '0;
    in_irq2_line  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    idle_pct      = 0;
    sent          = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    set_latency(16'd1);
    idle_pct = 20;
    send(FN_READ, '1, '0, '0, 1'b0);
    send(FN_WRITE, 5'(IO_REG_COUNT), '1, '0, 1'b0);
    // clks meets the all-ones disk timer left by reset
    send(FN_WRITE, REG_CLKS, '1, '0, 1'b0);
    send(FN_TICK, '0, '0, '0, 1'b1);
    send(FN_WRITE, REG_EN1, 32'd1, '0, 1'b0);
    send(FN_WRITE, REG_HANDLER, '1, '0, 1'b0);
    send(FN_CHECK, '0, '0, '1, 1'b0);
    send(FN_CHECK, '0, '0, '0, 1'b0);
    send(FN_RETURN, '0, '0, '0, 1'b0);
    send(FN_RETURN, '0, '0, '0, 1'b0);
    send(FN_WRITE, REG_ST1, '0, '0, 1'b0);
    send(FN_CHECK, '0, '0, '0, 1'b0);
    send(FN_WRITE, REG_TMAX, 32'd1, '0, 1'b0);
    send(FN_WRITE, REG_TEN, 32'h8000_0000, '0, 1'b0);
    send(FN_WRITE, REG_EN0, 32'd1, '0, 1'b0);
    send(FN_TICK, '0, '0, '0, 1'b0);
    send(FN_TICK, '0, '0, '0, 1'b0);
    send(FN_CHECK, '0, '0, '0, 1'b0);
    send(FN_WRITE, REG_DCMD, '0, '0, 1'b0);
    send(FN_WRITE, REG_DCMD, '1, '0, 1'b0);
    send(FN_TICK, '0, '0, '0, 1'b0);
    send(FN_TICK, '0, '0, '0, 1'b0);
    send(FN_READ, REG_ST1, '0, '0, 1'b0);
    send(FN_WRITE, REG_MCMD, '1, '0, 1'b0);
    send(FN_TICK, '0, '0, '0, 1'b0);
    send(FN_READ, REG_MCMD, '0, '0, 1'b0);
    send(FN_SPARE_FIRST, '0, '1, '1, 1'b1);
    send(FN_SPARE_LAST, '1, '1, '1, 1'b1);

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_latency(DISK_LAT_RESET);
        1:       set_latency('1);
        2:       set_latency(16'd1);
        3:       set_latency(16'($urandom_range(64, 2)));
        4:       set_latency(16'd3);
        default: set_latency(16'($urandom_range(65535, 1)));
      endcase
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        if (phase == 5) idle_pct = 0;
        else case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
        case ($urandom_range(9))
          0, 1: begin
            // disk command, then jump clks to completion or just short of it
            base = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15) : $urandom();
            send(FN_WRITE, REG_CLKS, base, rnd_pc(), rnd_bit());
            send(FN_WRITE, REG_DCMD, ($urandom_range(7) == 0) ? '0 : ($urandom() | 32'd1),
                 rnd_pc(), rnd_bit());
            k = $urandom_range(3);
            send(FN_WRITE, REG_CLKS, base + cur_lat - k, rnd_pc(), rnd_bit());
            repeat ($urandom_range(6, 1)) send(FN_TICK, rnd_addr(), $urandom(), rnd_pc(),
                                               rnd_bit());
            send(FN_READ, REG_DSTAT, $urandom(), rnd_pc(), rnd_bit());
            send(FN_READ, REG_ST1, $urandom(), rnd_pc(), rnd_bit());
          end
          2, 3: begin
            k = $urandom_range(2);
            send(FN_WRITE, 5'(REG_EN0 + k), ($urandom_range(3) == 0) ? '0 : any_word(),
                 rnd_pc(), rnd_bit());
            send(FN_WRITE, REG_HANDLER, $urandom(), rnd_pc(), rnd_bit());
            if ($urandom_range(1)) send(FN_WRITE, 5'(REG_ST0 + k), any_word(), rnd_pc(),
                                        rnd_bit());
            repeat ($urandom_range(3)) send(FN_TICK, rnd_addr(), $urandom(), rnd_pc(),
                                            rnd_bit());
            send(FN_CHECK, rnd_addr(), $urandom(), rnd_pc(), rnd_bit());
            if ($urandom_range(1)) send(FN_CHECK, rnd_addr(), $urandom(), rnd_pc(),
                                        rnd_bit());
            send(FN_RETURN, rnd_addr(), $urandom(), rnd_pc(), rnd_bit());
            send(FN_WRITE, 5'(REG_ST0 + k), '0, rnd_pc(), rnd_bit());
          end
          4, 5: begin
            send(FN_WRITE, REG_TMAX, $urandom_range(5), rnd_pc(), rnd_bit());
            send(FN_WRITE, REG_TCUR, ($urandom_range(1)) ? word_t'($urandom_range(5)) :
                 any_word(), rnd_pc(), rnd_bit());
            send(FN_WRITE, REG_TEN, ($urandom_range(3) == 0) ? '0 : any_word(), rnd_pc(),
                 rnd_bit());
            repeat ($urandom_range(8, 1)) send(FN_TICK, rnd_addr(), $urandom(), rnd_pc(),
                                               rnd_bit());
            send(FN_READ, REG_TCUR, $urandom(), rnd_pc(), rnd_bit());
            send(FN_READ, REG_ST0, $urandom(), rnd_pc(), rnd_bit());
          end
          default: begin
            fn = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) :
                 3'($urandom_range(FN_SPARE_LAST, FN_SPARE_FIRST));
            send(fn, rnd_addr(), any_word(), rnd_pc(), rnd_bit());
          end
        endcase
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (5) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
